// File: rtl/b2nv12_pkg.sv
// ----------------------------------------------------------------------------
// b2nv12_pkg
// Shared widths, register indexes and BT.709 fixed-point constants for the
// BGRA to NV12 converter.
// ----------------------------------------------------------------------------
package b2nv12_pkg;

    // Payload widths
    localparam int COMP_W      = 8;    // one color component
    localparam int INDEX_W     = 24;   // plane byte index
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    // Defaults
    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int MAX_HEIGHT_DEF   = 4096;
    localparam int WIDTH_RESET      = 1920;
    localparam int HEIGHT_RESET     = 1080;

    // Packed pixel pair: three 9-bit fields, B low, G middle, R high
    localparam int FIELD_W = 9;
    localparam int PAIR_W  = 3 * FIELD_W;
    localparam int SUM_W   = FIELD_W + 1;   // 2x2 block sum, up to 1020

    // Luma, Q16, coefficients sum to 65536
    localparam int Y_COEF_R = 13933;
    localparam int Y_COEF_G = 46871;
    localparam int Y_COEF_B = 4732;
    localparam int Y_ROUND  = 32768;
    localparam int Y_PROD_W = 24;

    // Chroma, Q18 (Q16 coefficient and divide by four), magnitudes only
    localparam int U_COEF_R = 7510;    // subtracted
    localparam int U_COEF_G = 25258;   // subtracted
    localparam int U_COEF_B = 32768;   // added
    localparam int V_COEF_R = 32768;   // added
    localparam int V_COEF_G = 29766;   // subtracted
    localparam int V_COEF_B = 3002;    // subtracted
    localparam int C_OFFSET = (128 << 18) + (1 << 17);
    localparam int C_PROD_W = 25;
    localparam int C_ACC_W  = 28;

endpackage

// File: rtl/b2nv12_ifs.sv
// ----------------------------------------------------------------------------
// b2nv12 channel interfaces
// Pixel input, result output and configuration write channels, each a
// valid/ready channel with source and sink modports.
// ----------------------------------------------------------------------------
interface b2nv12_pix_if import b2nv12_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
    logic              frame_start;

    modport source (output valid, blue, green, red, frame_start, input ready);
    modport sink   (input valid, blue, green, red, frame_start, output ready);
endinterface

interface b2nv12_res_if import b2nv12_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               plane;
    logic [INDEX_W-1:0] plane_index;
    logic [COMP_W-1:0]  first_value;
    logic [COMP_W-1:0]  second_value;
    logic               last;

    modport source (output valid, plane, plane_index, first_value, second_value, last,
                    input ready);
    modport sink   (input valid, plane, plane_index, first_value, second_value, last,
                    output ready);
endinterface

interface b2nv12_cfg_if import b2nv12_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bgra_to_nv12_bt709.sv
// ----------------------------------------------------------------------------
// bgra_to_nv12_bt709
// Streaming BGRA to full-range BT.709 NV12 converter, one pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : raster-order pixels (blue, green, red). frame_start on the first
//            pixel of a frame zeroes the column/row position.
//   result : one luma transaction per pixel (plane 0). A pixel that closes a
//            2x2 block (odd or last column, with odd or last row) is followed
//            by one chroma transaction (plane 1, first=U, second=V). last
//            marks the final transaction caused by a pixel.
//   cfg    : frame_width (index 0) and frame_height (index 1); 0 acts as 1,
//            values above MAX_WIDTH/MAX_HEIGHT saturate. Always ready. Write
//            only while no pixel is in flight.
// Path: a pixel goes into the input register at acceptance; its luma
//   transaction is formed in the output register once that register is
//   open, and can be taken from there.
// Throughput: 1 pixel per cycle while result is ready and no chroma
//   transaction is pending; a block-closing pixel holds the output register
//   for its luma and its chroma transaction, and this serialization sets it.
// Reset: positions and register valids clear, sizes return to 1920x1080.
//   The upper-row pair memory is not cleared; it is always written in an
//   even row before the odd row below reads it.
// Stall: a stalled result holds the output register; pixels keep flowing
//   into the input register until both are full, then pixel.ready drops.
// ----------------------------------------------------------------------------
module bgra_to_nv12_bt709
    import b2nv12_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    b2nv12_pix_if.sink    pixel,
    b2nv12_res_if.source  result,
    b2nv12_cfg_if.sink    cfg
);

    // Position and size widths
    localparam int CW = $clog2(MAX_WIDTH);        // column
    localparam int RW = $clog2(MAX_HEIGHT);       // row
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width register
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // height register
    localparam int UD = (MAX_WIDTH + 1) / 2;      // column pairs per row
    localparam int AW = (UD > 1) ? $clog2(UD) : 1;
    localparam int LP_W = RW + WW;                // row * width product
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    // ------------------------------------------------------------------------
    // Configuration: sizes are stored already clamped
    // ------------------------------------------------------------------------
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [WW-1:0] w_cfg;
    logic [HW-1:0] h_cfg;
    logic          cfg_fire;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;

    assign w_cfg = (cfg.data == '0) ? WW'(1) :
                   (32'(cfg.data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg.data);
    assign h_cfg = (cfg.data == '0) ? HW'(1) :
                   (32'(cfg.data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WW'(W_RST);
            h_reg <= HW'(H_RST);
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:  w_reg <= w_cfg;
                CFG_FRAME_HEIGHT: h_reg <= h_cfg;
                default:          ;   // unknown register, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake: the input register moves when the output register is open.
    // The output register opens once its final transaction is taken.
    // ------------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg;
    logic s2_phase_reg, s2_chroma_reg;
    logic s2_done, s2_open, s1_open;
    logic pix_fire, res_fire;

    assign res_fire = result.valid & result.ready;
    assign s2_done  = res_fire & result.last;
    assign s2_open  = ~s2_valid_reg | s2_done;
    assign s1_open  = ~s1_valid_reg | s2_open;

    assign pixel.ready = s1_open;
    assign pix_fire    = pixel.valid & pixel.ready;

    // ------------------------------------------------------------------------
    // Stage 0: position tracking, pair sums, upper-row memory access
    // ------------------------------------------------------------------------
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [PAIR_W-1:0] pair_sum_reg;

    logic [CW-1:0]     c0, cur_col;
    logic [RW-1:0]     r0, cur_row;
    logic [HW-1:0]     r1;
    logic              col_wrap, last_col, last_row;
    logic              close_col, close_row;
    logic [PAIR_W-1:0] px, pair;
    logic [AW-1:0]     slot;
    logic              mem_wr, mem_rd;

    assign c0 = pixel.frame_start ? '0 : col_reg;
    assign r0 = pixel.frame_start ? '0 : row_reg;

    // A position left at or past the size by a register change wraps here
    assign col_wrap = (WW'(c0) >= w_reg);
    assign r1       = col_wrap ? (HW'(r0) + HW'(1)) : HW'(r0);
    assign cur_col  = col_wrap ? '0 : c0;
    assign cur_row  = (r1 >= h_reg) ? '0 : r1[RW-1:0];

    assign last_col  = (WW'(cur_col) == (w_reg - WW'(1)));
    assign last_row  = (HW'(cur_row) == (h_reg - HW'(1)));
    assign close_col = cur_col[0] | last_col;
    assign close_row = cur_row[0] | last_row;

    assign col_next = last_col ? '0 : (cur_col + CW'(1));
    assign row_next = !last_col ? cur_row :
                      (last_row ? '0 : (cur_row + RW'(1)));

    assign px   = {1'b0, pixel.red, 1'b0, pixel.green, 1'b0, pixel.blue};
    // Fields never carry: each holds at most 255 + 255
    assign pair = cur_col[0] ? (pair_sum_reg + px) : px;
    assign slot = AW'(cur_col >> 1);

    assign mem_wr = pix_fire & close_col & ~close_row;
    assign mem_rd = pix_fire & close_col & close_row & cur_row[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pair_sum_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!cur_col[0])
            begin
                pair_sum_reg <= px;
            end
        end
    end

    // Upper-row pair sums, one entry per column pair
    logic [PAIR_W-1:0] upper_mem [0:UD-1];
    logic [PAIR_W-1:0] upper_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            upper_mem[slot] <= pair;
        end
        if (mem_rd)
        begin
            upper_rdata_reg <= upper_mem[slot];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 register: the accepted pixel with its position
    // ------------------------------------------------------------------------
    logic [COMP_W-1:0] s1_blue_reg, s1_green_reg, s1_red_reg;
    logic [PAIR_W-1:0] s1_pair_reg;
    logic              s1_up_reg, s1_chroma_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_open)
        begin
            s1_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_blue_reg   <= pixel.blue;
            s1_green_reg  <= pixel.green;
            s1_red_reg    <= pixel.red;
            s1_pair_reg   <= pair;
            s1_up_reg     <= cur_row[0];   // last even row has no row above
            s1_chroma_reg <= close_col & close_row;
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 -> output: block sums, constant products, round, saturate,
    // plane indexes
    // ------------------------------------------------------------------------
    logic [PAIR_W-1:0]   up_pair;
    logic [SUM_W-1:0]    sum_b, sum_g, sum_r;
    logic [LP_W-1:0]     lum_prod, chr_prod;
    logic [Y_PROD_W-1:0] y_r_prod, y_g_prod, y_b_prod;
    logic [C_PROD_W-1:0] u_r_prod, u_g_prod, u_b_prod;
    logic [C_PROD_W-1:0] v_r_prod, v_g_prod, v_b_prod;

    assign up_pair = s1_up_reg ? upper_rdata_reg : '0;
    assign sum_b = SUM_W'(s1_pair_reg[FIELD_W-1:0]) + SUM_W'(up_pair[FIELD_W-1:0]);
    assign sum_g = SUM_W'(s1_pair_reg[2*FIELD_W-1:FIELD_W])
                 + SUM_W'(up_pair[2*FIELD_W-1:FIELD_W]);
    assign sum_r = SUM_W'(s1_pair_reg[3*FIELD_W-1:2*FIELD_W])
                 + SUM_W'(up_pair[3*FIELD_W-1:2*FIELD_W]);

    assign lum_prod = LP_W'(s1_row_reg) * LP_W'(w_reg);
    assign chr_prod = LP_W'(s1_row_reg >> 1) * LP_W'(w_reg);

    assign y_r_prod = Y_PROD_W'(s1_red_reg) * Y_PROD_W'(Y_COEF_R);
    assign y_g_prod = Y_PROD_W'(s1_green_reg) * Y_PROD_W'(Y_COEF_G);
    assign y_b_prod = Y_PROD_W'(s1_blue_reg) * Y_PROD_W'(Y_COEF_B);
    assign u_r_prod = C_PROD_W'(sum_r) * C_PROD_W'(U_COEF_R);
    assign u_g_prod = C_PROD_W'(sum_g) * C_PROD_W'(U_COEF_G);
    assign u_b_prod = C_PROD_W'(sum_b) * C_PROD_W'(U_COEF_B);
    assign v_r_prod = C_PROD_W'(sum_r) * C_PROD_W'(V_COEF_R);
    assign v_g_prod = C_PROD_W'(sum_g) * C_PROD_W'(V_COEF_G);
    assign v_b_prod = C_PROD_W'(sum_b) * C_PROD_W'(V_COEF_B);

    function automatic logic [COMP_W-1:0] chroma_sat(input logic [C_ACC_W-1:0] acc);
        logic [C_ACC_W-19:0] q;
        q = acc[C_ACC_W-1:18];
        if (acc[C_ACC_W-1])
        begin
            return '0;                   // negative: clamp to zero
        end
        else if (q > (C_ACC_W-18)'(255))
        begin
            return {COMP_W{1'b1}};       // 256 saturates to 255
        end
        return q[COMP_W-1:0];
    endfunction

    logic [Y_PROD_W-1:0] y_acc;
    logic [C_ACC_W-1:0]  u_acc, v_acc;
    logic [INDEX_W-1:0]  l_index, c_index;

    assign y_acc = y_r_prod + y_g_prod + y_b_prod + Y_PROD_W'(Y_ROUND);
    assign u_acc = C_ACC_W'(C_OFFSET) + C_ACC_W'(u_b_prod)
                 - C_ACC_W'(u_r_prod) - C_ACC_W'(u_g_prod);
    assign v_acc = C_ACC_W'(C_OFFSET) + C_ACC_W'(v_r_prod)
                 - C_ACC_W'(v_g_prod) - C_ACC_W'(v_b_prod);

    // modulo 2^24
    assign l_index = INDEX_W'(lum_prod) + INDEX_W'(s1_col_reg);
    assign c_index = INDEX_W'(chr_prod) + (INDEX_W'(s1_col_reg) & ~INDEX_W'(1));

    logic [INDEX_W-1:0] s2_lindex_reg, s2_cindex_reg;
    logic [COMP_W-1:0]  s2_luma_reg, s2_u_reg, s2_v_reg;

    // phase 0 shows the luma transaction, phase 1 the chroma transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_phase_reg <= 1'b0;
        end
        else if (s2_open)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_phase_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            s2_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_open && s1_valid_reg)
        begin
            s2_chroma_reg <= s1_chroma_reg;
            s2_lindex_reg <= l_index;
            s2_cindex_reg <= c_index;
            s2_luma_reg   <= y_acc[Y_PROD_W-1:16];
            s2_u_reg      <= chroma_sat(u_acc);
            s2_v_reg      <= chroma_sat(v_acc);
        end
    end

    // ------------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------------
    assign result.valid        = s2_valid_reg;
    assign result.plane        = s2_phase_reg;
    assign result.plane_index  = s2_phase_reg ? s2_cindex_reg : s2_lindex_reg;
    assign result.first_value  = s2_phase_reg ? s2_u_reg : s2_luma_reg;
    assign result.second_value = s2_phase_reg ? s2_v_reg : '0;
    assign result.last         = s2_phase_reg | ~s2_chroma_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A luma transaction that is not last is always followed by its chroma
    a_chroma_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && !result.last) |=> (result.valid && result.plane))
        else $error("chroma transaction did not follow its luma transaction");

    // An item in the input register is never dropped while the output is busy
    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_open) |=> s1_valid_reg)
        else $error("input register item lost during output stall");

    // frame_start places the pixel at column 0, so the next column is 1 (0 at width 1)
    a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && pixel.frame_start && !cfg_fire)
        |=> (col_reg == ((w_reg == WW'(1)) ? '0 : CW'(1))))
        else $error("column position wrong after frame_start");

endmodule
